>>> rtl/btr_pkg.sv
// ----------------------------------------------------------------------------
// btr_pkg
// Shared types and constants for the 8x8 bitmap text renderer.
// ----------------------------------------------------------------------------
package btr_pkg;

    localparam int GLYPH_COUNT_DEF = 256;
    localparam int ROWS_PER_GLYPH  = 8;

    localparam int CODE_W  = 8;
    localparam int ROW_W   = 3;
    localparam int BITS_W  = 8;
    localparam int ORG_W   = 12;
    localparam int WORD_W  = 32;
    localparam int PITCH_W = 16;
    localparam int PEN_W   = 16;
    localparam int OFF_W   = 10;
    localparam int XBASE_W = 14;
    localparam int POS_W   = 16;
    localparam int CNT_W   = 6;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DRAW = 1'b1
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LINE_PITCH = 1'b0,
        CFG_FRAME_BASE = 1'b1
    } t_cfg_idx;

    localparam logic [CODE_W-1:0]  CODE_NUL     = 8'd0;
    localparam logic [CODE_W-1:0]  CODE_NEWLINE = 8'd10;
    localparam logic [CODE_W-1:0]  CODE_RETURN  = 8'd13;

    localparam logic [PEN_W-1:0]   PEN_STEP     = 16'd8;
    localparam logic [PITCH_W-1:0] PITCH_RESET  = 16'd7680;
    localparam logic [WORD_W-1:0]  FBASE_RESET  = 32'd0;

endpackage

>>> rtl/btr_in_if.sv
// ----------------------------------------------------------------------------
// btr_in_if
// Input item channel: glyph row loads and text characters.
// ----------------------------------------------------------------------------
interface btr_in_if;
    import btr_pkg::*;

    logic               valid;
    logic               ready;
    logic               op;
    logic               start_req;
    logic [CODE_W-1:0]  char_code;
    logic [ROW_W-1:0]   glyph_row;
    logic [BITS_W-1:0]  glyph_bits;
    logic [ORG_W-1:0]   origin_x;
    logic [ORG_W-1:0]   origin_y;
    logic [WORD_W-1:0]  fg_color;
    logic [WORD_W-1:0]  bg_color;

    modport source (
        output valid, op, start_req, char_code, glyph_row, glyph_bits,
               origin_x, origin_y, fg_color, bg_color,
        input  ready
    );
    modport sink (
        input  valid, op, start_req, char_code, glyph_row, glyph_bits,
               origin_x, origin_y, fg_color, bg_color,
        output ready
    );
endinterface

>>> rtl/btr_out_if.sv
// ----------------------------------------------------------------------------
// btr_out_if
// Pixel write channel toward the framebuffer.
// ----------------------------------------------------------------------------
interface btr_out_if;
    import btr_pkg::*;

    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] pixel_addr;
    logic [WORD_W-1:0] pixel_color;
    logic              last;

    modport source (
        output valid, pixel_addr, pixel_color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_addr, pixel_color, last,
        output ready
    );
endinterface

>>> rtl/btr_cfg_if.sv
// ----------------------------------------------------------------------------
// btr_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface btr_cfg_if;
    import btr_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

>>> rtl/btr_ram.sv
// ----------------------------------------------------------------------------
// btr_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module btr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

>>> rtl/bitmap_text_string_renderer_core.sv
// ----------------------------------------------------------------------------
// bitmap_text_string_renderer_core
// Draws 8x8 glyphs into a 32-bit framebuffer, one pixel per unstalled cycle.
//
//   channel  dir  transfer carries
//   i_in     in   glyph row load, or one text character
//   o_out    out  pixel address, pixel word, last of character
//   i_cfg    in   register index and write data
//
// A printable character gives 64 pixel writes at one per cycle when the output
// does not stall; the pixel sequencer and the single glyph RAM read port set
// that rate. Control codes and loads give none. A load waits until queued
// draws have read their glyph rows. One character may wait in a pending slot
// while the previous one drains; output stalls hold the pipe. Reset is
// synchronous; the glyph RAM is not cleared.
// ----------------------------------------------------------------------------
module bitmap_text_string_renderer_core #(
    parameter int GLYPH_COUNT = btr_pkg::GLYPH_COUNT_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    btr_in_if.sink     i_in,
    btr_out_if.source  o_out,
    btr_cfg_if.sink    i_cfg
);
    import btr_pkg::*;

    localparam int DEPTH = GLYPH_COUNT * ROWS_PER_GLYPH;
    localparam int AW    = $clog2(DEPTH);

    // architectural state
    logic [PITCH_W-1:0] r_pitch;
    logic [WORD_W-1:0]  r_fbase;
    logic [PEN_W-1:0]   r_pen,  n_pen;
    logic [ORG_W-1:0]   r_base, n_base;
    logic [OFF_W-1:0]   r_off,  n_off;
    logic [WORD_W-1:0]  r_fg,   n_fg;
    logic [WORD_W-1:0]  r_bg,   n_bg;

    // pending character
    logic               r_pv;
    logic [CODE_W-1:0]  r_p_code;
    logic               r_p_ok;
    logic [XBASE_W-1:0] r_p_xbase;
    logic [PEN_W-1:0]   r_p_pen;
    logic [WORD_W-1:0]  r_p_fg;
    logic [WORD_W-1:0]  r_p_bg;

    // pixel sequencer
    logic               r_act;
    logic [CNT_W-1:0]   r_cnt;
    logic [CODE_W-1:0]  r_code;
    logic               r_ok;
    logic [XBASE_W-1:0] r_xbase;
    logic [WORD_W-1:0]  r_line;
    logic [WORD_W-1:0]  r_fg1;
    logic [WORD_W-1:0]  r_bg1;

    // glyph read stage
    logic               r_v2;
    logic [WORD_W-1:0]  r_s2_addr;
    logic [ROW_W-1:0]   r_s2_col;
    logic [WORD_W-1:0]  r_s2_fg;
    logic [WORD_W-1:0]  r_s2_bg;
    logic               r_s2_ok;
    logic               r_s2_last;

    // output register
    logic               r_v3;
    logic [WORD_W-1:0]  r_o_addr;
    logic [WORD_W-1:0]  r_o_color;
    logic               r_o_last;

    logic               in_acc;
    logic               draw_acc;
    logic               load_acc;
    logic               en3;
    logic               en2;
    logic               seq_end;
    logic               p_take;
    logic               printable;
    logic [OFF_W-1:0]   off_s;
    logic [ORG_W-1:0]   base_s;
    logic [POS_W-1:0]   pos;
    logic [OFF_W-1:0]   off_w;
    logic [XBASE_W-1:0] xbase;
    logic               code_ok;
    logic [WORD_W-1:0]  p_line;
    logic [XBASE_W-1:0] xcol;
    logic [WORD_W-1:0]  pix_addr;
    logic [AW-1:0]      raddr;
    logic [AW-1:0]      waddr;
    logic [BITS_W-1:0]  rdata;

    assign en3      = !r_v3 || o_out.ready;
    assign en2      = !r_v2 || en3;
    assign seq_end  = r_act && en2 && (&r_cnt);
    assign p_take   = r_pv && (!r_act || seq_end);

    assign i_in.ready = (i_in.op == OP_DRAW) ? (!r_pv || p_take) : (!r_pv && !r_act);
    assign in_acc   = i_in.valid && i_in.ready;
    assign draw_acc = in_acc && (i_in.op == OP_DRAW);
    assign load_acc = in_acc && (i_in.op == OP_LOAD);

    assign i_cfg.ready = 1'b1;

    assign code_ok  = {1'b0, i_in.char_code} < (CODE_W+1)'(GLYPH_COUNT);
    assign printable = (i_in.char_code != CODE_NUL) && (i_in.char_code != CODE_NEWLINE)
                     && (i_in.char_code != CODE_RETURN);

    assign base_s = i_in.start_req ? i_in.origin_x : r_base;
    assign off_s  = i_in.start_req ? '0 : r_off;
    assign pos    = POS_W'({base_s, 2'b00}) + POS_W'({off_s, 5'b00000});
    assign off_w  = (pos >= r_pitch) ? '0 : off_s;
    assign xbase  = XBASE_W'(base_s) + XBASE_W'({off_w, 3'b000});

    always_comb begin
        n_base = base_s;
        n_pen  = i_in.start_req ? PEN_W'(i_in.origin_y) : r_pen;
        n_fg   = i_in.start_req ? i_in.fg_color : r_fg;
        n_bg   = i_in.start_req ? i_in.bg_color : r_bg;
        n_off  = off_s;
        if (i_in.char_code == CODE_NEWLINE) begin
            n_pen = n_pen + PEN_STEP;
            n_off = '0;
        end else if (i_in.char_code == CODE_RETURN) begin
            n_off = '0;
        end else if (i_in.char_code != CODE_NUL) begin
            n_off = off_w + OFF_W'(1);
        end
    end

    assign p_line   = {{(WORD_W-PEN_W){1'b0}}, r_p_pen} * {{(WORD_W-PITCH_W){1'b0}}, r_pitch};
    assign xcol     = r_xbase + XBASE_W'(r_cnt[ROW_W-1:0]);
    assign pix_addr = r_fbase + r_line + WORD_W'({xcol, 2'b00});

    assign raddr = AW'({r_code, r_cnt[CNT_W-1:ROW_W]});
    assign waddr = AW'({i_in.char_code, i_in.glyph_row});

    btr_ram #(
        .WIDTH (BITS_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_glyph_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc && code_ok),
        .i_waddr (waddr),
        .i_wdata (i_in.glyph_bits),
        .i_re    (r_act && en2),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pitch <= PITCH_RESET;
            r_fbase <= FBASE_RESET;
            r_pen   <= '0;
            r_base  <= '0;
            r_off   <= '0;
            r_fg    <= '0;
            r_bg    <= '0;
            r_pv    <= 1'b0;
            r_act   <= 1'b0;
            r_cnt   <= '0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                case (i_cfg.index)
                    CFG_LINE_PITCH: r_pitch <= i_cfg.data[PITCH_W-1:0];
                    CFG_FRAME_BASE: r_fbase <= i_cfg.data[WORD_W-1:0];
                    default: ;
                endcase
            end
            if (draw_acc) begin
                r_pen  <= n_pen;
                r_base <= n_base;
                r_off  <= n_off;
                r_fg   <= n_fg;
                r_bg   <= n_bg;
            end
            if (draw_acc && printable) begin
                r_pv <= 1'b1;
            end else if (p_take) begin
                r_pv <= 1'b0;
            end
            if (p_take) begin
                r_act <= 1'b1;
                r_cnt <= '0;
            end else if (r_act && en2) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (&r_cnt) begin
                    r_act <= 1'b0;
                end
            end
            if (en2) begin
                r_v2 <= r_act;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (draw_acc && printable) begin
            r_p_code  <= i_in.char_code;
            r_p_ok    <= code_ok;
            r_p_xbase <= xbase;
            r_p_pen   <= n_pen;
            r_p_fg    <= n_fg;
            r_p_bg    <= n_bg;
        end
        if (p_take) begin
            r_code  <= r_p_code;
            r_ok    <= r_p_ok;
            r_xbase <= r_p_xbase;
            r_line  <= p_line;
            r_fg1   <= r_p_fg;
            r_bg1   <= r_p_bg;
        end else if (r_act && en2 && (&r_cnt[ROW_W-1:0])) begin
            r_line <= r_line + WORD_W'(r_pitch);
        end
        if (en2 && r_act) begin
            r_s2_addr <= pix_addr;
            r_s2_col  <= r_cnt[ROW_W-1:0];
            r_s2_fg   <= r_fg1;
            r_s2_bg   <= r_bg1;
            r_s2_ok   <= r_ok;
            r_s2_last <= &r_cnt;
        end
        if (en3 && r_v2) begin
            r_o_addr  <= r_s2_addr;
            r_o_color <= (r_s2_ok && rdata[r_s2_col]) ? r_s2_fg : r_s2_bg;
            r_o_last  <= r_s2_last;
        end
    end

    assign o_out.valid       = r_v3;
    assign o_out.pixel_addr  = r_o_addr;
    assign o_out.pixel_color = r_o_color;
    assign o_out.last        = r_o_last;

`ifndef SYNTHESIS
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_acc |-> (!r_pv && !r_act))
        else $error("glyph load accepted while a draw is queued");

    a_pend_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pv && !p_take) |-> !(draw_acc && printable))
        else $error("pending character overwritten");

    a_seq_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_end |=> (r_v2 && r_s2_last))
        else $error("end of character not marked last");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !en3) |=> r_v2)
        else $error("read stage dropped a pixel under stall");
`endif
endmodule
